### rtl/core/alt_pkg.sv
// Shared types, character codes, token codes and character classes for the line tokenizer.
`default_nettype none

package alt_pkg;

  localparam int START_W = 7;
  localparam int LENGTH_W = 8;
  localparam int CHAR_W = 8;
  localparam int KIND_W = 2;
  localparam int STATUS_W = 2;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [1:0] pend_t;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_FETCH = 1'b1;

  localparam char_t CHAR_COMMA = 8'h2c;
  localparam char_t CHAR_LBRACK = 8'h5b;
  localparam char_t CHAR_RBRACK = 8'h5d;
  localparam char_t CHAR_EQUAL = 8'h3d;
  localparam char_t CHAR_QUOTE = 8'h22;
  localparam char_t CHAR_NL = 8'h0a;
  localparam char_t CHAR_TAB = 8'h09;
  localparam char_t CHAR_SPACE = 8'h20;

  localparam kind_t KIND_WORD = 2'd0;
  localparam kind_t KIND_DELIM = 2'd1;
  localparam kind_t KIND_QUOTED = 2'd2;

  localparam status_t STAT_TOKEN = 2'd0;
  localparam status_t STAT_DONE = 2'd1;
  localparam status_t STAT_NOT_READY = 2'd2;

  localparam pend_t PEND_NONE = 2'd0;
  localparam pend_t PEND_QUOTED = 2'd1;
  localparam pend_t PEND_CLOSE = 2'd2;
  localparam pend_t PEND_REST = 2'd3;

  function automatic logic is_blank(input char_t c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB);
  endfunction

  function automatic logic is_delim(input char_t c);
    return (c == CHAR_COMMA) || (c == CHAR_LBRACK) || (c == CHAR_RBRACK) ||
           (c == CHAR_EQUAL) || (c == CHAR_NL);
  endfunction

endpackage

`default_nettype wire

### rtl/core/alt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module alt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/core/assembly_line_tokenizer.sv
// Top level of the line tokenizer: line store, scan sequencer and result register.
// Push: accepted back to back while no fetch is in progress; no result.
// Fetch: accepted while idle, then the scan walks the line from the cursor, then the result
//   is loaded into the output register once it is free; a status-only fetch skips the scan.
//   The single read port of the line store is read one character a cycle by the scan.
// Reset (rst_n low, synchronous) empties the line and clears out_valid; store contents
//   are left as they are and are never used before being written.
`default_nettype none

module assembly_line_tokenizer #(
  parameter int LINE_DEPTH = 128
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   in_mode,
  input  wire alt_pkg::char_t         in_char_in,
  input  wire logic                   in_line_end,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [alt_pkg::START_W-1:0] out_token_start,
  output logic [alt_pkg::LENGTH_W-1:0] out_token_length,
  output alt_pkg::kind_t              out_token_kind,
  output alt_pkg::char_t              out_token_char,
  output alt_pkg::status_t            out_fetch_status,
  output logic                        out_overflow
);

  import alt_pkg::*;

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int LW = $clog2(LINE_DEPTH + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_BLANK = 3'd1;
  localparam logic [2:0] ST_WORD  = 3'd2;
  localparam logic [2:0] ST_RAW   = 3'd3;
  localparam logic [2:0] ST_QUOTE = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [AW-1:0] lq_r, lq_nxt;
  logic [LW-1:0] cursor_r, cursor_nxt;
  pend_t         pend_r, pend_nxt;
  logic          ready_r, ready_nxt;
  logic          finished_r, finished_nxt;
  logic          ovf_r, ovf_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [LW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] res_start_r, res_start_nxt;
  logic [LW-1:0] res_len_r, res_len_nxt;
  kind_t         res_kind_r, res_kind_nxt;
  char_t         res_char_r, res_char_nxt;
  status_t       res_stat_r, res_stat_nxt;

  logic [START_W-1:0]  out_start_r, out_start_nxt;
  logic [LENGTH_W-1:0] out_len_r, out_len_nxt;
  kind_t               out_kind_r, out_kind_nxt;
  char_t               out_char_r, out_char_nxt;
  status_t             out_stat_r, out_stat_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  char_t         q;
  logic [LW-1:0] len_eff;
  logic [LW-1:0] lq_ext;
  logic [LW-1:0] start_ext;

  alt_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(LINE_DEPTH)
  ) u_line_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(in_char_in),
    .raddr(pos_nxt[AW-1:0]),
    .rdata(q)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign len_eff   = ready_r ? '0 : len_r;
  assign lq_ext    = LW'(lq_r);
  assign start_ext = LW'(res_start_r);

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    lq_nxt        = lq_r;
    cursor_nxt    = cursor_r;
    pend_nxt      = pend_r;
    ready_nxt     = ready_r;
    finished_nxt  = finished_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    pos_nxt       = pos_r;
    res_start_nxt = res_start_r;
    res_len_nxt   = res_len_r;
    res_kind_nxt  = res_kind_r;
    res_char_nxt  = res_char_r;
    res_stat_nxt  = res_stat_r;
    out_start_nxt = out_start_r;
    out_len_nxt   = out_len_r;
    out_kind_nxt  = out_kind_r;
    out_char_nxt  = out_char_r;
    out_stat_nxt  = out_stat_r;
    out_ovf_nxt   = out_ovf_r;
    ram_we        = 1'b0;
    ram_waddr     = len_eff[AW-1:0];

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_PUSH) begin
            if (ready_r) begin
              len_nxt      = '0;
              lq_nxt       = '0;
              cursor_nxt   = '0;
              pend_nxt     = PEND_NONE;
              ready_nxt    = 1'b0;
              finished_nxt = 1'b0;
              ovf_nxt      = 1'b0;
            end
            if (len_eff < LW'(LINE_DEPTH)) begin
              ram_we  = 1'b1;
              len_nxt = len_eff + 1'b1;
              if (in_char_in == CHAR_QUOTE) begin
                lq_nxt = len_eff[AW-1:0];
              end
            end else begin
              ovf_nxt = 1'b1;
            end
            if (in_line_end) begin
              ready_nxt = 1'b1;
            end
          end else if (!ready_r || finished_r) begin
            res_stat_nxt  = ready_r ? STAT_DONE : STAT_NOT_READY;
            res_start_nxt = '0;
            res_len_nxt   = '0;
            res_kind_nxt  = KIND_WORD;
            res_char_nxt  = '0;
            state_nxt     = ST_OUT;
          end else begin
            pos_nxt       = cursor_r;
            res_start_nxt = cursor_r[AW-1:0];
            unique case (pend_r) inside
              PEND_NONE:                state_nxt = ST_BLANK;
              PEND_REST:                state_nxt = ST_RAW;
              PEND_QUOTED, PEND_CLOSE:  state_nxt = ST_QUOTE;
              default:                  state_nxt = ST_BLANK;
            endcase
          end
        end
      end

      ST_BLANK: begin
        if (pos_r >= len_r) begin
          cursor_nxt    = pos_r;
          finished_nxt  = 1'b1;
          res_stat_nxt  = STAT_DONE;
          res_start_nxt = '0;
          res_len_nxt   = '0;
          res_kind_nxt  = KIND_WORD;
          res_char_nxt  = '0;
          state_nxt     = ST_OUT;
        end else if (is_blank(q)) begin
          pos_nxt = pos_r + 1'b1;
        end else if (is_delim(q) || q == CHAR_QUOTE) begin
          cursor_nxt    = pos_r + 1'b1;
          res_stat_nxt  = STAT_TOKEN;
          res_start_nxt = pos_r[AW-1:0];
          res_len_nxt   = LW'(1);
          res_kind_nxt  = KIND_DELIM;
          res_char_nxt  = q;
          state_nxt     = ST_OUT;
          if (q == CHAR_QUOTE) begin
            pend_nxt = (pos_r == lq_ext) ? PEND_REST : PEND_QUOTED;
          end
        end else begin
          res_start_nxt = pos_r[AW-1:0];
          res_char_nxt  = q;
          pos_nxt       = pos_r + 1'b1;
          state_nxt     = ST_WORD;
        end
      end

      ST_WORD: begin
        if (pos_r >= len_r || is_blank(q) || is_delim(q) || q == CHAR_QUOTE) begin
          cursor_nxt   = pos_r;
          res_stat_nxt = STAT_TOKEN;
          res_len_nxt  = pos_r - start_ext;
          res_kind_nxt = KIND_WORD;
          state_nxt    = ST_OUT;
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
      end

      ST_RAW: begin
        if (pos_r < len_r && q != CHAR_NL) begin
          if (pos_r == cursor_r) begin
            res_char_nxt = q;
          end
          pos_nxt = pos_r + 1'b1;
        end else if (pos_r != cursor_r) begin
          cursor_nxt   = pos_r;
          res_stat_nxt = STAT_TOKEN;
          res_len_nxt  = pos_r - cursor_r;
          res_kind_nxt = KIND_QUOTED;
          state_nxt    = ST_OUT;
        end else if (pos_r < len_r) begin
          finished_nxt = 1'b1;
          res_stat_nxt = STAT_TOKEN;
          res_len_nxt  = LW'(1);
          res_kind_nxt = KIND_DELIM;
          res_char_nxt = q;
          state_nxt    = ST_OUT;
        end else begin
          finished_nxt  = 1'b1;
          res_stat_nxt  = STAT_DONE;
          res_start_nxt = '0;
          res_len_nxt   = '0;
          res_kind_nxt  = KIND_WORD;
          res_char_nxt  = '0;
          state_nxt     = ST_OUT;
        end
      end

      ST_QUOTE: begin
        state_nxt = ST_OUT;
        if (pend_r == PEND_QUOTED && pos_r < lq_ext) begin
          cursor_nxt   = lq_ext;
          pend_nxt     = PEND_CLOSE;
          res_stat_nxt = STAT_TOKEN;
          res_len_nxt  = lq_ext - pos_r;
          res_kind_nxt = KIND_QUOTED;
          res_char_nxt = q;
        end else begin
          pend_nxt = PEND_NONE;
          if (pos_r >= len_r) begin
            finished_nxt  = 1'b1;
            res_stat_nxt  = STAT_DONE;
            res_start_nxt = '0;
            res_len_nxt   = '0;
            res_kind_nxt  = KIND_WORD;
            res_char_nxt  = '0;
          end else begin
            cursor_nxt   = pos_r + 1'b1;
            res_stat_nxt = STAT_TOKEN;
            res_len_nxt  = LW'(1);
            res_kind_nxt = KIND_DELIM;
            res_char_nxt = q;
          end
        end
      end

      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_start_nxt = START_W'(res_start_r);
          out_len_nxt   = LENGTH_W'(res_len_r);
          out_kind_nxt  = res_kind_r;
          out_char_nxt  = res_char_r;
          out_stat_nxt  = res_stat_r;
          out_ovf_nxt   = ovf_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      lq_r        <= '0;
      cursor_r    <= '0;
      pend_r      <= PEND_NONE;
      ready_r     <= 1'b0;
      finished_r  <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      lq_r        <= lq_nxt;
      cursor_r    <= cursor_nxt;
      pend_r      <= pend_nxt;
      ready_r     <= ready_nxt;
      finished_r  <= finished_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    res_start_r <= res_start_nxt;
    res_len_r   <= res_len_nxt;
    res_kind_r  <= res_kind_nxt;
    res_char_r  <= res_char_nxt;
    res_stat_r  <= res_stat_nxt;
    out_start_r <= out_start_nxt;
    out_len_r   <= out_len_nxt;
    out_kind_r  <= out_kind_nxt;
    out_char_r  <= out_char_nxt;
    out_stat_r  <= out_stat_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_token_start  = out_start_r;
  assign out_token_length = out_len_r;
  assign out_token_kind   = out_kind_r;
  assign out_token_char   = out_char_r;
  assign out_fetch_status = out_stat_r;
  assign out_overflow     = out_ovf_r;

  a_finished_needs_ready: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> ready_r)
    else $error("line marked finished without a complete line");

  a_cursor_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= len_r)
    else $error("scan cursor beyond line length");

  a_scan_needs_open_line: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BLANK || state_r == ST_WORD || state_r == ST_RAW ||
     state_r == ST_QUOTE) |-> (ready_r && !finished_r && pos_r <= len_r))
    else $error("scan running without an open complete line");

  a_status_clears_token: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stat_r != STAT_TOKEN) |->
      (out_start_r == '0 && out_len_r == '0 && out_kind_r == KIND_WORD && out_char_r == '0))
    else $error("status-only transaction carries token fields");

  a_token_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && res_stat_r == STAT_TOKEN) |-> (res_len_r != '0))
    else $error("empty token produced");

endmodule

`default_nettype wire
